### hdl/athash_pkg.sv
package athash_pkg;

  localparam int unsigned TABLE_ENTRIES = 32768;
  localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned COUNT_W = SLOT_W + 1;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam int unsigned HASH_SHIFT = 13;

  localparam logic [31:0] KEY_EMPTY = 32'd0;
  localparam logic [31:0] KEY_TOMB = 32'd1;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_REKEY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  // Slot store request from the sequencer
  typedef struct packed {
    logic              rd;
    logic              wr_key;
    logic              wr_data;
    logic [SLOT_W-1:0] addr;
    logic [31:0]       key;
    logic [31:0]       site;
    logic [31:0]       size;
    logic [31:0]       epoch;
  } mem_req_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] site;
    logic [31:0] size;
    logic [31:0] epoch;
  } mem_rsp_t;

endpackage

### hdl/athash_hash.sv
// Multiplicative hash of key >> 4, one registered multiply
module athash_hash (
  input  logic                            clk,
  input  logic [31:0]                     key,
  output logic [athash_pkg::SLOT_W-1:0]   home
);

  logic [31:0] prod;

  // Low 32 bits of the product, registered
  always_ff @(posedge clk) begin
    prod <= ({4'd0, key[31:4]} * athash_pkg::HASH_MULT);
  end

  assign home = athash_pkg::SLOT_W'(prod >> athash_pkg::HASH_SHIFT);

endmodule

### hdl/athash_store.sv
// Slot stores; key store has a clearing pass driven by the sequencer
module athash_store (
  input  logic                 clk,
  input  athash_pkg::mem_req_t req,
  output athash_pkg::mem_rsp_t rsp
);

  logic [31:0] key_mem   [athash_pkg::TABLE_ENTRIES];
  logic [31:0] site_mem  [athash_pkg::TABLE_ENTRIES];
  logic [31:0] size_mem  [athash_pkg::TABLE_ENTRIES];
  logic [31:0] epoch_mem [athash_pkg::TABLE_ENTRIES];

  // Write and read keys and payload
  always_ff @(posedge clk) begin
    if (req.wr_key) begin
      key_mem[req.addr] <= req.key;
    end
    if (req.wr_data) begin
      site_mem[req.addr]  <= req.site;
      size_mem[req.addr]  <= req.size;
      epoch_mem[req.addr] <= req.epoch;
    end
    if (req.rd) begin
      rsp.key   <= key_mem[req.addr];
      rsp.site  <= site_mem[req.addr];
      rsp.size  <= size_mem[req.addr];
      rsp.epoch <= epoch_mem[req.addr];
    end
  end

endmodule

### hdl/alloc_tracking_hash_table_core.sv
// Allocation tracking table: open addressing with linear probing and
// tombstones over 32768 slots. After reset the key store is cleared by a pass
// over every slot, during which no item is taken. An item with a reserved key
// goes to the result straight after its accepting cycle. Any other item is set
// up in accept, hash and home slot steps, then reads and checks each slot it
// probes through the single read port of the slot store; a slot is written in
// the cycle that checks it. A rekey goes through the done, hash and home slot
// states for the new key before it probes for it. A result waits in an output
// register and the next item may enter only once it has been taken.
module alloc_tracking_hash_table_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // operation[1:0], key_address[33:2], new_address[65:34],
  // alloc_size[97:66], call_site[129:98], zero fill to 136
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], found_call_site[33:2], found_size[65:34],
  // live_entries[81:66], sequence_now[113:82], zero fill to 120
  output logic [119:0] m_tdata
);

  localparam int unsigned SW = athash_pkg::SLOT_W;
  localparam int unsigned CW = athash_pkg::COUNT_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HOME  = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]    state;
  logic [SW-1:0] clr_addr;
  logic [1:0]    op;
  logic [31:0]   key, nkey, size;
  logic          phase_ins;   // probing to insert (record or rekey second half)
  logic [31:0]   probe_key;
  logic [SW-1:0] slot;
  logic [CW-1:0] probed;
  logic          have_tomb;
  logic [SW-1:0] tomb;
  logic [31:0]   keep_site, keep_epoch;
  logic [15:0]   live_total;
  logic [31:0]   seq;
  logic [1:0]    status;
  logic [31:0]   fsite, fsize;
  logic [SW-1:0] home;
  logic [31:0]   hash_key;

  athash_pkg::mem_req_t req;
  athash_pkg::mem_rsp_t rsp;

  athash_hash u_hash (.clk(clk), .key(hash_key), .home(home));
  athash_store u_store (.clk(clk), .req(req), .rsp(rsp));

  assign hash_key = probe_key;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {6'd0, seq, live_total, fsize, fsite, status};

  logic k_empty, k_hit, k_tomb, wrapped;
  assign k_empty = (rsp.key == athash_pkg::KEY_EMPTY);
  assign k_hit   = (rsp.key == probe_key);
  assign k_tomb  = (rsp.key == athash_pkg::KEY_TOMB);
  assign wrapped = (probed == CW'(athash_pkg::TABLE_ENTRIES - 1));

  logic reserved_nkey;
  assign reserved_nkey = (nkey == athash_pkg::KEY_EMPTY) ||
                         (nkey == athash_pkg::KEY_TOMB);

  logic reserved_in;
  assign reserved_in = (s_tdata[33:2] == athash_pkg::KEY_EMPTY) ||
                       (s_tdata[33:2] == athash_pkg::KEY_TOMB);

  // Drive the slot store request
  always_comb begin
    req = '0;
    req.key   = probe_key;
    req.size  = size;
    req.site  = keep_site;
    req.epoch = keep_epoch;
    unique case (state)
      S_CLEAR: begin
        req.wr_key = 1'b1;
        req.addr   = clr_addr;
        req.key    = athash_pkg::KEY_EMPTY;
      end
      S_READ: begin
        req.rd   = 1'b1;
        req.addr = slot;
      end
      default: req.addr = slot;
    endcase
    // Writes are issued from S_CHECK
    if (state == S_CHECK) begin
      req.addr = slot;
      if (phase_ins) begin
        if (k_hit) begin
          req.wr_key = 1'b1; req.wr_data = 1'b1;
        end else if (k_empty) begin
          req.wr_key = 1'b1; req.wr_data = 1'b1;
          if (have_tomb) req.addr = tomb;
        end else if (wrapped && (have_tomb || k_tomb)) begin
          req.wr_key = 1'b1; req.wr_data = 1'b1;
          if (have_tomb) req.addr = tomb;
        end
      end else if (k_hit && !k_empty && (op == athash_pkg::OP_REMOVE ||
                   (op == athash_pkg::OP_REKEY && nkey != key))) begin
        req.wr_key = 1'b1;
        req.key    = athash_pkg::KEY_TOMB;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      live_total <= '0;
      seq        <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SW'(athash_pkg::TABLE_ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[1:0];
            key   <= s_tdata[33:2];
            nkey  <= s_tdata[65:34];
            size  <= s_tdata[97:66];
            probe_key <= s_tdata[33:2];
            keep_site  <= s_tdata[129:98];
            keep_epoch <= seq + 32'd1;
            fsite  <= '0;
            fsize  <= '0;
            status <= athash_pkg::ST_OK;
            phase_ins <= (s_tdata[1:0] == athash_pkg::OP_RECORD);
            if (s_tdata[1:0] == athash_pkg::OP_RECORD) seq <= seq + 32'd1;
            if (reserved_in) begin
              status <= athash_pkg::ST_RESERVED;
              state  <= S_OUT;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: state <= S_HOME;
        S_HOME: begin
          slot      <= home;
          probed    <= '0;
          have_tomb <= 1'b0;
          state     <= S_READ;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (phase_ins) begin
            if (k_hit) begin
              state <= S_OUT;
            end else if (k_empty || (wrapped && (have_tomb || k_tomb))) begin
              live_total <= live_total + 16'd1;
              state <= S_OUT;
            end else if (wrapped) begin
              status <= athash_pkg::ST_FULL;
              state  <= S_OUT;
            end else begin
              if (k_tomb && !have_tomb) begin
                have_tomb <= 1'b1;
                tomb      <= slot;
              end
              slot   <= slot + 1'b1;
              probed <= probed + 1'b1;
              state  <= S_READ;
            end
          end else if (k_empty || (!k_hit && wrapped)) begin
            status <= athash_pkg::ST_MISSING;
            state  <= S_OUT;
          end else if (k_hit) begin
            unique case (op)
              athash_pkg::OP_LOOKUP: begin
                fsite <= rsp.site;
                fsize <= rsp.size;
                state <= S_OUT;
              end
              athash_pkg::OP_REMOVE: begin
                live_total <= live_total - 16'd1;
                state <= S_OUT;
              end
              default: begin
                keep_site  <= rsp.site;
                keep_epoch <= rsp.epoch;
                if (nkey != key) live_total <= live_total - 16'd1;
                state <= S_DONE;
              end
            endcase
          end else begin
            slot   <= slot + 1'b1;
            probed <= probed + 1'b1;
            state  <= S_READ;
          end
        end
        S_DONE: begin
          // Start the insert half of a rekey, or report a reserved new key
          if (reserved_nkey) begin
            status <= athash_pkg::ST_RESERVED;
            state  <= S_OUT;
          end else begin
            probe_key <= nkey;
            phase_ins <= 1'b1;
            state     <= S_HASH;
          end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1:0] == athash_pkg::OP_RECORD |=> seq == $past(seq) + 32'd1)
    else $error("sequence not advanced");
  a_no_double: assert property (@(posedge clk) disable iff (rst)
    req.wr_key |-> !req.rd)
    else $error("read and write together");

endmodule
